// File: hw/rtl/cf_pkg.sv
package cf_pkg;

    localparam int DATA_W   = 32;
    localparam int CFG_W    = 4;
    localparam int IDX_OUT_W = 3;
    localparam int ACC_W    = 64;
    localparam int FRAC_W   = 16;
    localparam int RAD_W    = 31;
    localparam int ROOT_W   = 24;
    localparam int SQ_W     = 48;
    localparam int SQ_STEPS = 24;
    localparam int DIV_STEPS = 32;
    localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

    typedef struct packed {
        logic load;
        logic clr;
        logic rd;
        logic rd_a;
        logic sqrt_go;
        logic div_go;
        logic wr_l;
        logic wr_div;
        logic out_rd;
        logic out_zero;
        logic out_last;
        logic fail;
    } t_cmd;

    typedef struct packed {
        logic rad_bad;
        logic sqrt_done;
        logic div_done;
    } t_stat;

endpackage

// File: hw/rtl/cf_sqrt.sv
module cf_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [cf_pkg::RAD_W-1:0]      i_rad,
    output logic                          o_done,
    output logic [cf_pkg::ROOT_W-1:0]     o_root
);

    logic [cf_pkg::SQ_W-1:0] r_v, r_res, r_bit;
    logic [4:0]              r_step;
    logic                    r_busy, r_done;
    logic [cf_pkg::SQ_W-1:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == 5'(cf_pkg::SQ_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // one result bit per cycle, radicand is rad scaled by 2^16
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_v    <= {1'b0, i_rad, 16'b0};
            r_res  <= '0;
            r_bit  <= cf_pkg::SQ_W'(1) << (cf_pkg::SQ_W - 2);
            r_step <= '0;
        end else if (r_busy) begin
            if (r_v >= w_trial) begin
                r_v   <= r_v - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit  <= r_bit >> 2;
            r_step <= r_step + 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[cf_pkg::ROOT_W-1:0];

endmodule

// File: hw/rtl/cf_div.sv
module cf_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic signed [cf_pkg::ACC_W-1:0]   i_num,
    input  logic [cf_pkg::ROOT_W-1:0]         i_den,
    output logic                              o_done,
    output logic [cf_pkg::DATA_W-1:0]         o_quo
);

    logic                          r_neg, r_ovf, r_busy, r_done;
    logic [cf_pkg::ROOT_W-1:0]     r_rem;
    logic [31:0]                   r_sh, r_q;
    logic [5:0]                    r_step;
    logic [cf_pkg::ACC_W-1:0]      w_mag;
    logic [cf_pkg::ROOT_W:0]       w_t;
    logic                          w_ge;

    assign w_mag = i_num[cf_pkg::ACC_W-1] ? (~i_num + 64'd1) : i_num;
    assign w_t   = {r_rem, r_sh[31]};
    assign w_ge  = w_t >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == 6'(cf_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // restoring division of |num|*2^16 by the pivot, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_neg  <= i_num[cf_pkg::ACC_W-1];
            r_ovf  <= w_mag >= {24'b0, i_den, 16'b0};
            r_rem  <= w_mag[39:16];
            r_sh   <= {w_mag[15:0], 16'b0};
            r_q    <= '0;
            r_step <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? cf_pkg::ROOT_W'(w_t - {1'b0, i_den})
                           : w_t[cf_pkg::ROOT_W-1:0];
            r_sh   <= r_sh << 1;
            r_q    <= {r_q[30:0], w_ge};
            r_step <= r_step + 6'd1;
        end
    end

    always_comb begin
        if (r_ovf) begin
            o_quo = r_neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else if (r_neg) begin
            o_quo = (r_q > 32'h8000_0000) ? 32'h8000_0000 : (~r_q + 32'd1);
        end else begin
            o_quo = r_q[31] ? 32'h7fff_ffff : r_q;
        end
    end

    assign o_done = r_done;

endmodule

// File: hw/rtl/cf_dp.sv
module cf_dp #(
    parameter int MAX_ORDER = 8,
    localparam int CELLS = MAX_ORDER * MAX_ORDER,
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cf_pkg::t_cmd                        i_cmd,
    output cf_pkg::t_stat                       o_stat,
    input  logic signed [cf_pkg::DATA_W-1:0]    i_a_value,
    input  logic [AW-1:0]                       i_load_addr,
    input  logic [AW-1:0]                       i_a_addr,
    input  logic [AW-1:0]                       i_l_addr1,
    input  logic [AW-1:0]                       i_l_addr2,
    input  logic [AW-1:0]                       i_l_waddr,
    input  logic [cf_pkg::IDX_OUT_W-1:0]        i_out_row,
    input  logic [cf_pkg::IDX_OUT_W-1:0]        i_out_col,
    output logic                                o_valid,
    output logic signed [cf_pkg::DATA_W-1:0]    o_l_value,
    output logic [cf_pkg::IDX_OUT_W-1:0]        o_out_row,
    output logic [cf_pkg::IDX_OUT_W-1:0]        o_out_col,
    output logic                                o_last_of_matrix,
    output logic                                o_not_pos_def
);

    logic [cf_pkg::DATA_W-1:0]         a_mem [CELLS];
    logic [cf_pkg::DATA_W-1:0]         l_mem [CELLS];
    logic signed [cf_pkg::DATA_W-1:0]  r_a, r_l1, r_l2;
    logic signed [cf_pkg::ACC_W-1:0]   r_prod, r_acc;
    logic                              r_v1, r_v2;
    logic [cf_pkg::ROOT_W-1:0]         r_piv;
    logic                              r_ov, r_zero, r_last, r_fail;
    logic [cf_pkg::IDX_OUT_W-1:0]      r_row, r_col;

    logic signed [cf_pkg::ACC_W-1:0]   w_rnd, w_rad;
    logic                              w_sq_done, w_div_done;
    logic [cf_pkg::ROOT_W-1:0]         w_root;
    logic [cf_pkg::DATA_W-1:0]         w_quo;

    // round half up: floor((p + 2^15) / 2^16)
    assign w_rnd = (r_prod + 64'sd32768) >>> cf_pkg::FRAC_W;
    assign w_rad = cf_pkg::ACC_W'(r_a) - r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            a_mem[i_load_addr] <= i_a_value;
        end
        if (i_cmd.rd_a) begin
            r_a <= a_mem[i_a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_l) begin
            l_mem[i_l_waddr] <= i_cmd.wr_div ? w_quo
                                             : cf_pkg::DATA_W'(w_root);
        end
        if (i_cmd.rd || i_cmd.out_rd) begin
            r_l1 <= l_mem[i_l_addr1];
        end
        if (i_cmd.rd) begin
            r_l2 <= l_mem[i_l_addr2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd;
            r_v2 <= r_v1;
            r_ov <= i_cmd.out_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= r_l1 * r_l2;
        end
        if (i_cmd.clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + w_rnd;
        end
        if (i_cmd.wr_l && !i_cmd.wr_div) begin
            r_piv <= w_root;
        end
        if (i_cmd.out_rd) begin
            r_zero <= i_cmd.out_zero;
            r_last <= i_cmd.out_last;
            r_fail <= i_cmd.fail;
            r_row  <= i_out_row;
            r_col  <= i_out_col;
        end
    end

    cf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.sqrt_go),
        .i_rad   (w_rad[cf_pkg::RAD_W-1:0]),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    cf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (w_rad),
        .i_den   (r_piv),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_stat.rad_bad   = w_rad[cf_pkg::ACC_W-1] || (w_rad == '0);
    assign o_stat.sqrt_done = w_sq_done;
    assign o_stat.div_done  = w_div_done;

    assign o_valid          = r_ov;
    assign o_l_value        = r_zero ? '0 : r_l1;
    assign o_out_row        = r_row;
    assign o_out_col        = r_col;
    assign o_last_of_matrix = r_last;
    assign o_not_pos_def    = r_fail;

endmodule

// File: hw/rtl/cf_ctrl.sv
module cf_ctrl #(
    parameter int MAX_ORDER = 8,
    localparam int CELLS = MAX_ORDER * MAX_ORDER,
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_valid,
    input  logic [cf_pkg::CFG_W-1:0]      i_cfg_data,
    output cf_pkg::t_cmd                  o_cmd,
    input  cf_pkg::t_stat                 i_stat,
    output logic [AW-1:0]                 o_load_addr,
    output logic [AW-1:0]                 o_a_addr,
    output logic [AW-1:0]                 o_l_addr1,
    output logic [AW-1:0]                 o_l_addr2,
    output logic [AW-1:0]                 o_l_waddr,
    output logic [cf_pkg::IDX_OUT_W-1:0]  o_out_row,
    output logic [cf_pkg::IDX_OUT_W-1:0]  o_out_col
);

    localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int OW    = $clog2(MAX_ORDER + 1);
    localparam int CW    = $clog2(CELLS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DOT   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_SQRT  = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]               r_state, n_state;
    logic [cf_pkg::CFG_W-1:0] r_size;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [OW-1:0]            r_n, n_n, r_failcol, n_failcol;
    logic [IW-1:0]            r_i, n_i, r_j, n_j, r_k, n_k, r_r, n_r, r_c, n_c;
    logic [1:0]               r_drain, n_drain;
    logic                     r_fail, n_fail;
    logic [OW-1:0]            w_n;
    logic [CW-1:0]            w_cnt_inc;
    logic                     w_last;

    function automatic logic [AW-1:0] flat(input logic [IW-1:0] row,
                                           input logic [IW-1:0] col,
                                           input logic [OW-1:0] n);
        return AW'(int'(row) * int'(n) + int'(col));
    endfunction

    always_comb begin
        if (r_size == '0) begin
            w_n = OW'(1);
        end else if (int'(r_size) > MAX_ORDER) begin
            w_n = OW'(MAX_ORDER);
        end else begin
            w_n = OW'(r_size);
        end
    end

    assign w_cnt_inc = (int'(r_cnt) < CELLS) ? r_cnt + CW'(1) : r_cnt;
    assign w_last    = (int'(r_r) == int'(r_n) - 1) && (int'(r_c) == int'(r_n) - 1);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_failcol   = r_failcol;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_r         = r_r;
        n_c         = r_c;
        n_drain     = r_drain;
        n_fail      = r_fail;
        o_cmd       = '0;
        o_cmd.fail  = r_fail;
        o_load_addr = r_cnt[AW-1:0];
        o_a_addr    = flat(r_j, r_i, r_n);
        o_l_addr1   = flat(r_j, r_k, r_n);
        o_l_addr2   = flat(r_i, r_k, r_n);
        o_l_waddr   = flat(r_j, r_i, r_n);
        o_out_row   = cf_pkg::IDX_OUT_W'(r_r);
        o_out_col   = cf_pkg::IDX_OUT_W'(r_c);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = int'(r_cnt) < CELLS;
                    n_cnt      = w_cnt_inc;
                    if (int'(w_cnt_inc) >= int'(w_n) * int'(w_n)) begin
                        n_cnt     = '0;
                        n_n       = w_n;
                        n_i       = '0;
                        n_j       = '0;
                        n_fail    = 1'b0;
                        n_failcol = w_n;
                        n_state   = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.clr  = 1'b1;
                o_cmd.rd_a = 1'b1;
                n_k        = '0;
                n_state    = S_DOT;
            end
            S_DOT: begin
                if (r_k < r_i) begin
                    o_cmd.rd = 1'b1;
                    n_k      = r_k + IW'(1);
                end else begin
                    n_drain = 2'd3;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // let the multiply and accumulate stages empty
                if (r_drain == 2'd0) begin
                    n_state = S_EVAL;
                end else begin
                    n_drain = r_drain - 2'd1;
                end
            end
            S_EVAL: begin
                if (r_j == r_i) begin
                    if (i_stat.rad_bad) begin
                        n_fail    = 1'b1;
                        n_failcol = OW'(r_i);
                        n_r       = '0;
                        n_c       = '0;
                        n_state   = S_OUT;
                    end else begin
                        o_cmd.sqrt_go = 1'b1;
                        n_state       = S_SQRT;
                    end
                end else begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.wr_l = 1'b1;
                    if (int'(r_i) + 1 < int'(r_n)) begin
                        n_j     = r_i + IW'(1);
                        n_state = S_START;
                    end else begin
                        n_r     = '0;
                        n_c     = '0;
                        n_state = S_OUT;
                    end
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_l   = 1'b1;
                    o_cmd.wr_div = 1'b1;
                    if (int'(r_j) + 1 < int'(r_n)) begin
                        n_j = r_j + IW'(1);
                    end else begin
                        // next column starts at its diagonal
                        n_i = r_i + IW'(1);
                        n_j = r_i + IW'(1);
                    end
                    n_state = S_START;
                end
            end
            S_OUT: begin
                o_cmd.out_rd   = 1'b1;
                o_l_addr1      = flat(r_r, r_c, r_n);
                o_cmd.out_zero = (r_c > r_r) || (int'(r_c) >= int'(r_failcol));
                o_cmd.out_last = w_last;
                if (w_last) begin
                    n_state = S_IDLE;
                end else if (int'(r_c) == int'(r_n) - 1) begin
                    n_c = '0;
                    n_r = r_r + IW'(1);
                end else begin
                    n_c = r_c + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= cf_pkg::SIZE_RESET;
            r_cnt   <= '0;
            r_fail  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fail  <= n_fail;
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_failcol <= n_failcol;
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_r       <= n_r;
        r_c       <= n_c;
        r_drain   <= n_drain;
    end

    assign busy = r_state != S_IDLE;

endmodule

// File: hw/rtl/cholesky_factorization_top.sv
// Loads an n-by-n matrix (signed Q16.16, row-major) one word per cycle while start is high
// and busy is low; the word that completes the matrix starts the factorization and busy
// rises. Each entry of L takes a multiply-accumulate over its k earlier columns (one
// shared multiplier), then a square root on the diagonal or a division below it; the
// bit-serial root and divide units set most of the time. L is then sent row-major, n*n
// words at one word per cycle, marked by o_valid. The receiver cannot stall: every
// result is on the ports for one cycle only and must be taken then.
module cholesky_factorization_top #(
    parameter int MAX_ORDER = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [cf_pkg::DATA_W-1:0]  i_a_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cf_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                              o_valid,
    output logic signed [cf_pkg::DATA_W-1:0]  o_l_value,
    output logic [cf_pkg::IDX_OUT_W-1:0]      o_out_row,
    output logic [cf_pkg::IDX_OUT_W-1:0]      o_out_col,
    output logic                              o_last_of_matrix,
    output logic                              o_not_pos_def
);

    localparam int CELLS = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    cf_pkg::t_cmd                   w_cmd;
    cf_pkg::t_stat                  w_stat;
    logic [AW-1:0]                  w_load_addr, w_a_addr, w_l_addr1, w_l_addr2, w_l_waddr;
    logic [cf_pkg::IDX_OUT_W-1:0]   w_row, w_col;

    assign o_cfg_ready = 1'b1;

    cf_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat),
        .o_load_addr (w_load_addr),
        .o_a_addr    (w_a_addr),
        .o_l_addr1   (w_l_addr1),
        .o_l_addr2   (w_l_addr2),
        .o_l_waddr   (w_l_waddr),
        .o_out_row   (w_row),
        .o_out_col   (w_col)
    );

    cf_dp #(.MAX_ORDER(MAX_ORDER)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_a_value        (i_a_value),
        .i_load_addr      (w_load_addr),
        .i_a_addr         (w_a_addr),
        .i_l_addr1        (w_l_addr1),
        .i_l_addr2        (w_l_addr2),
        .i_l_waddr        (w_l_waddr),
        .i_out_row        (w_row),
        .i_out_col        (w_col),
        .o_valid          (o_valid),
        .o_l_value        (o_l_value),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_last_of_matrix (o_last_of_matrix),
        .o_not_pos_def    (o_not_pos_def)
    );

endmodule
